FILE: rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pas_pkg.sv
// Types and constants for the priority aging scheduler.
// No dependencies; imported by pas_ctrl, pas_dpath and the top level.
package pas_pkg;

   localparam int TASK_W    = 4;
   localparam int TPRI_W    = 4;
   localparam int AGE_W     = 8;
   localparam int CFG_W     = 8;
   localparam int FLOOR_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W     = 2;
   localparam int STS_W     = 2;

   localparam logic [REQ_W-1:0] REQ_READY    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WITHDRAW = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK     = 2'd2;

   localparam logic [STS_W-1:0] STS_DONE = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL = 2'd1;
   localparam logic [STS_W-1:0] STS_MISS = 2'd2;
   localparam logic [STS_W-1:0] STS_IDLE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_LIMIT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIORITY_FLOOR = 2'd2;

   localparam logic [CFG_W-1:0]   SLICE_RST     = 8'd10;
   localparam logic [CFG_W-1:0]   AGE_LIMIT_RST = 8'd8;
   localparam logic [FLOOR_W-1:0] FLOOR_RST     = 4'd0;
   localparam logic [AGE_W-1:0]   AGE_MAX       = 8'hFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_WITHDRAW,
      ST_AGE,
      ST_DECIDE,
      ST_POP,
      ST_REINSERT,
      ST_DONE
   } pas_state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_LATCH,
      DP_INSERT,
      DP_WD_STEP,
      DP_AGE_STEP,
      DP_DECIDE,
      DP_POP,
      DP_REINSERT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic hit;
      logic do_switch;
      logic do_reinsert;
   } dp_status_type;

endpackage

FILE: rtl/priority_aging_scheduler_top.sv
// Make-ready latches and inserts; withdraw scans for a match and removes it; tick ages the
// queue, decides, and on a task change pops the head and requeues a still-running old task.
// Throughput: one request in flight; the next is taken at the edge where the result first
// shows; a result loads once the one before it is taken. Aging walks one entry a cycle.
// Synchronous active-high reset empties the queue, clears the running task and loads the
// register defaults. Top level: ties pas_ctrl and pas_dpath together; depends on pas_pkg.
module priority_aging_scheduler_top #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 4,
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pas_pkg::REQ_W-1:0]      req_type,
   input  logic [pas_pkg::TASK_W-1:0]     req_task_id,
   input  logic [pas_pkg::TPRI_W-1:0]     req_task_priority,
   input  logic                           req_running_still_active,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pas_pkg::STS_W-1:0]      rsp_status,
   output logic                           rsp_switched,
   output logic [pas_pkg::TASK_W-1:0]     rsp_active_task,
   output logic                           rsp_active_valid,
   output logic [CNT_W-1:0]               rsp_queued_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pas_pkg::CFG_W-1:0]      csr_wdata
);
   import pas_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   pas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   pas_dpath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_dpath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .sts                      (sts),
      .req_task_id              (req_task_id),
      .req_task_priority        (req_task_priority),
      .req_running_still_active (req_running_still_active),
      .csr_we                   (csr_valid && csr_ready),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .rsp_status               (rsp_status),
      .rsp_switched             (rsp_switched),
      .rsp_active_task          (rsp_active_task),
      .rsp_active_valid         (rsp_active_valid),
      .rsp_queued_count         (rsp_queued_count)
   );

endmodule

FILE: rtl/pas_dpath.sv
// Datapath: sorted ready queue in shift registers, running task, slice and config.
// Depends on pas_pkg and assert_macros.svh; driven by pas_ctrl commands.
module pas_dpath #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 4,
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pas_pkg::dp_cmd_type                 cmd,
   output pas_pkg::dp_status_type              sts,
   input  logic [pas_pkg::TASK_W-1:0]          req_task_id,
   input  logic [pas_pkg::TPRI_W-1:0]          req_task_priority,
   input  logic                                req_running_still_active,
   input  logic                                csr_we,
   input  logic [pas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pas_pkg::CFG_W-1:0]           csr_wdata,
   output logic [pas_pkg::STS_W-1:0]           rsp_status,
   output logic                                rsp_switched,
   output logic [pas_pkg::TASK_W-1:0]          rsp_active_task,
   output logic                                rsp_active_valid,
   output logic [CNT_W-1:0]                    rsp_queued_count
);
   import pas_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int PRI_W = PRIORITY_BITS;
   localparam int CW    = (PRI_W > FLOOR_W) ? PRI_W : FLOOR_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   // queue entries, no reset: only slots below the fill count are read
   logic [TASK_W-1:0] task_ff [QUEUE_DEPTH];
   logic [TASK_W-1:0] task_in [QUEUE_DEPTH];
   logic [PRI_W-1:0]  pri_ff  [QUEUE_DEPTH];
   logic [PRI_W-1:0]  pri_in  [QUEUE_DEPTH];
   logic [AGE_W-1:0]  age_ff  [QUEUE_DEPTH];
   logic [AGE_W-1:0]  age_in  [QUEUE_DEPTH];

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [TASK_W-1:0] id_ff, id_in;
   logic [PRI_W-1:0]  rpri_ff, rpri_in;
   logic              still_ff, still_in;
   logic [STS_W-1:0]  res_status_ff, res_status_in;
   logic              res_switched_ff, res_switched_in;
   logic [TASK_W-1:0] act_id_ff, act_id_in;
   logic [PRI_W-1:0]  act_pri_ff, act_pri_in;
   logic              act_flag_ff, act_flag_in;
   logic [CFG_W-1:0]  slice_ff, slice_in;
   logic [TASK_W-1:0] old_id_ff, old_id_in;
   logic [PRI_W-1:0]  old_pri_ff, old_pri_in;
   logic              run_ff, run_in;
   logic [CFG_W-1:0]  slice_len_ff, slice_len_in;
   logic [CFG_W-1:0]  age_limit_ff, age_limit_in;
   logic [FLOOR_W-1:0] floor_ff, floor_in;
   logic [STS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic              rsp_switched_ff, rsp_switched_in;
   logic [TASK_W-1:0] rsp_task_ff, rsp_task_in;
   logic              rsp_avalid_ff, rsp_avalid_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [IDX_W-1:0]  cur_idx;
   logic [TASK_W-1:0] cur_task;
   logic [PRI_W-1:0]  cur_pri;
   logic [AGE_W-1:0]  cur_age, age_next;
   logic              scan_end, hit, promote, running, stay, do_switch;
   logic [CFG_W-1:0]  slice_dec;
   logic [TASK_W-1:0] ins_task;
   logic [PRI_W-1:0]  ins_pri;
   logic [QUEUE_DEPTH-1:0] ins_m, rot_m, rm_m;

   assign cur_idx  = idx_ff[IDX_W-1:0];
   assign cur_task = task_ff[cur_idx];
   assign cur_pri  = pri_ff[cur_idx];
   assign cur_age  = age_ff[cur_idx];
   assign scan_end = (idx_ff >= fill_ff);
   assign hit      = !scan_end && (cur_task == id_ff);
   assign age_next = (cur_age == AGE_MAX) ? cur_age : cur_age + AGE_W'(1);
   assign promote  = (age_next >= age_limit_ff) && (CW'(cur_pri) > CW'(floor_ff));
   assign running  = act_flag_ff && still_ff;
   assign slice_dec = (running && slice_ff != '0) ? slice_ff - CFG_W'(1) : slice_ff;
   assign stay     = running && (slice_dec != '0) &&
                     ((fill_ff == '0) || (act_pri_ff <= pri_ff[0]));
   assign do_switch = !stay && (fill_ff != '0);
   assign ins_task = (cmd.op == DP_REINSERT) ? old_id_ff : id_ff;
   assign ins_pri  = (cmd.op == DP_REINSERT) ? old_pri_ff : rpri_ff;

   assign sts.scan_end    = scan_end;
   assign sts.hit         = hit;
   assign sts.do_switch   = do_switch;
   assign sts.do_reinsert = run_ff;

   // per-slot masks; the queue is sorted, so each mask is a thermometer
   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         ins_m[j] = ((CNT_W'(j) < fill_ff) && (pri_ff[j] > ins_pri)) ||
                    (CNT_W'(j) == fill_ff);
         rot_m[j] = ((CNT_W'(j) < idx_ff) && (pri_ff[j] >= cur_pri)) ||
                    (CNT_W'(j) == idx_ff);
         rm_m[j]  = (cmd.op == DP_POP) || (CNT_W'(j) >= idx_ff);
      end
   end

   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         task_in[j] = task_ff[j];
         pri_in[j]  = pri_ff[j];
         age_in[j]  = age_ff[j];
      end
      fill_in         = fill_ff;
      idx_in          = idx_ff;
      id_in           = id_ff;
      rpri_in         = rpri_ff;
      still_in        = still_ff;
      res_status_in   = res_status_ff;
      res_switched_in = res_switched_ff;
      act_id_in       = act_id_ff;
      act_pri_in      = act_pri_ff;
      act_flag_in     = act_flag_ff;
      slice_in        = slice_ff;
      old_id_in       = old_id_ff;
      old_pri_in      = old_pri_ff;
      run_in          = run_ff;

      case (cmd.op)
         DP_LATCH: begin
            idx_in          = '0;
            id_in           = req_task_id;
            rpri_in         = PRI_W'(req_task_priority);
            still_in        = req_running_still_active;
            res_status_in   = STS_DONE;
            res_switched_in = 1'b0;
            run_in          = 1'b0;
         end
         DP_INSERT, DP_REINSERT: begin
            if (fill_ff == FULL_CNT) begin
               res_status_in = STS_FULL;
            end else begin
               for (int j = 0; j < QUEUE_DEPTH; j++) begin
                  if (ins_m[j]) begin
                     if (j == 0 || !ins_m[j-1]) begin
                        task_in[j] = ins_task;
                        pri_in[j]  = ins_pri;
                        age_in[j]  = '0;
                     end else begin
                        task_in[j] = task_ff[j-1];
                        pri_in[j]  = pri_ff[j-1];
                        age_in[j]  = age_ff[j-1];
                     end
                  end
               end
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         DP_WD_STEP, DP_POP: begin
            if (cmd.op == DP_POP || hit) begin
               for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                  if (rm_m[j]) begin
                     task_in[j] = task_ff[j+1];
                     pri_in[j]  = pri_ff[j+1];
                     age_in[j]  = age_ff[j+1];
                  end
               end
               fill_in = fill_ff - CNT_W'(1);
            end else if (scan_end) begin
               res_status_in = STS_MISS;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         DP_AGE_STEP: begin
            if (!scan_end) begin
               if (promote) begin
                  // promoted entry moves behind its new equals, ahead of its old ones; the rest shift back
                  for (int j = 0; j < QUEUE_DEPTH; j++) begin
                     if (rot_m[j]) begin
                        if (j == 0 || !rot_m[j-1]) begin
                           task_in[j] = cur_task;
                           pri_in[j]  = cur_pri - PRI_W'(1);
                           age_in[j]  = '0;
                        end else begin
                           task_in[j] = task_ff[j-1];
                           pri_in[j]  = pri_ff[j-1];
                           age_in[j]  = age_ff[j-1];
                        end
                     end
                  end
               end else begin
                  age_in[cur_idx] = age_next;
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         DP_DECIDE: begin
            if (stay) begin
               slice_in = slice_dec;
            end else if (fill_ff == '0) begin
               if (running) begin
                  slice_in = slice_len_ff;
               end else begin
                  act_flag_in   = 1'b0;
                  act_id_in     = '0;
                  act_pri_in    = '0;
                  slice_in      = '0;
                  res_status_in = STS_IDLE;
               end
            end else begin
               old_id_in       = act_id_ff;
               old_pri_in      = act_pri_ff;
               run_in          = running;
               act_id_in       = task_ff[0];
               act_pri_in      = pri_ff[0];
               act_flag_in     = 1'b1;
               slice_in        = slice_len_ff;
               res_switched_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      slice_len_in = slice_len_ff;
      age_limit_in = age_limit_ff;
      floor_in     = floor_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SLICE_LENGTH:   slice_len_in = csr_wdata;
            CSR_AGE_LIMIT:      age_limit_in = csr_wdata;
            CSR_PRIORITY_FLOOR: floor_in     = csr_wdata[FLOOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_status_in   = rsp_status_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_task_in     = rsp_task_ff;
      rsp_avalid_in   = rsp_avalid_ff;
      rsp_count_in    = rsp_count_ff;
      if (cmd.rsp_load) begin
         rsp_status_in   = res_status_ff;
         rsp_switched_in = res_switched_ff;
         rsp_task_in     = act_flag_ff ? act_id_ff : '0;
         rsp_avalid_in   = act_flag_ff;
         rsp_count_in    = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         task_ff[j] <= task_in[j];
         pri_ff[j]  <= pri_in[j];
         age_ff[j]  <= age_in[j];
      end
      idx_ff          <= idx_in;
      id_ff           <= id_in;
      rpri_ff         <= rpri_in;
      still_ff        <= still_in;
      res_status_ff   <= res_status_in;
      res_switched_ff <= res_switched_in;
      old_id_ff       <= old_id_in;
      old_pri_ff      <= old_pri_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_task_ff     <= rsp_task_in;
      rsp_avalid_ff   <= rsp_avalid_in;
      rsp_count_ff    <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         act_id_ff    <= '0;
         act_pri_ff   <= '0;
         act_flag_ff  <= 1'b0;
         slice_ff     <= '0;
         run_ff       <= 1'b0;
         slice_len_ff <= SLICE_RST;
         age_limit_ff <= AGE_LIMIT_RST;
         floor_ff     <= FLOOR_RST;
      end else begin
         fill_ff      <= fill_in;
         act_id_ff    <= act_id_in;
         act_pri_ff   <= act_pri_in;
         act_flag_ff  <= act_flag_in;
         slice_ff     <= slice_in;
         run_ff       <= run_in;
         slice_len_ff <= slice_len_in;
         age_limit_ff <= age_limit_in;
         floor_ff     <= floor_in;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_switched     = rsp_switched_ff;
   assign rsp_active_task  = rsp_task_ff;
   assign rsp_active_valid = rsp_avalid_ff;
   assign rsp_queued_count = rsp_count_ff;

   `include "assert_macros.svh"

   `CHK_IMPLY(a_fill_range, clock, reset, 1'b1, fill_ff <= FULL_CNT, "queue count overflow")
   `CHK_IMPLY(a_idle_id, clock, reset, !act_flag_ff, act_id_ff == '0, "stale running id")
   `CHK_NEXT(a_age_keeps_fill, clock, reset, cmd.op == DP_AGE_STEP, $stable(fill_ff), "aging changed count")

endmodule

FILE: rtl/pas_ctrl.sv
// Controller: sequences one request through the datapath and owns rsp_valid.
// Depends on pas_pkg and assert_macros.svh.
module pas_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pas_pkg::REQ_W-1:0]    req_type,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pas_pkg::dp_cmd_type          cmd,
   input  pas_pkg::dp_status_type       sts
);
   import pas_pkg::*;

   pas_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = DP_NONE;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = DP_LATCH;
               case (req_type)
                  REQ_READY:    state_in = ST_INSERT;
                  REQ_WITHDRAW: state_in = ST_WITHDRAW;
                  REQ_TICK:     state_in = ST_AGE;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_INSERT: begin
            cmd.op   = DP_INSERT;
            state_in = ST_DONE;
         end
         ST_WITHDRAW: begin
            cmd.op = DP_WD_STEP;
            if (sts.scan_end || sts.hit) begin
               state_in = ST_DONE;
            end
         end
         ST_AGE: begin
            cmd.op = DP_AGE_STEP;
            if (sts.scan_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.op   = DP_DECIDE;
            state_in = sts.do_switch ? ST_POP : ST_DONE;
         end
         ST_POP: begin
            cmd.op   = DP_POP;
            state_in = sts.do_reinsert ? ST_REINSERT : ST_DONE;
         end
         ST_REINSERT: begin
            cmd.op   = DP_REINSERT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `include "assert_macros.svh"

   `CHK_NEXT(a_done_hands_off, clock, reset, state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall), state_ff == ST_IDLE && rsp_valid_ff, "result not loaded")
   `CHK_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE, "request accepted but idle")
   `CHK_IMPLY(a_load_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result outside done")

endmodule

FILE: tb/sv/pas_checker.sv
// Checker for the priority aging scheduler: watches the request, result and
// register channels, predicts each result and compares it field by field.
// Depends on pas_pkg for request, status and register codes.
module pas_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [pas_pkg::REQ_W-1:0]     req_type,
   input  logic [pas_pkg::TASK_W-1:0]    req_task_id,
   input  logic [pas_pkg::TPRI_W-1:0]    req_task_priority,
   input  logic                          req_running_still_active,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [pas_pkg::STS_W-1:0]     rsp_status,
   input  logic                          rsp_switched,
   input  logic [pas_pkg::TASK_W-1:0]    rsp_active_task,
   input  logic                          rsp_active_valid,
   input  logic [4:0]                    rsp_queued_count,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [pas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pas_pkg::CFG_W-1:0]     csr_wdata,
   output int                            mismatches,
   output int                            outstanding,
   output int                            results_seen,
   output int                            switches_seen,
   output int                            idles_seen,
   output int                            drops_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import pas_pkg::*;

   typedef struct {
      logic [STS_W-1:0]  status;
      logic              switched;
      logic [TASK_W-1:0] task_id;
      logic              task_valid;
      logic [4:0]        count;
   } sched_outcome_type;

   sched_outcome_type sched_outcomes[$];

   logic [TASK_W-1:0] ready_task[QUEUE_DEPTH];
   logic [TPRI_W-1:0] ready_pri[QUEUE_DEPTH];
   logic [AGE_W-1:0]  ready_age[QUEUE_DEPTH];
   int                ready_fill;
   logic [TASK_W-1:0] run_id;
   logic              run_flag;
   logic [TPRI_W-1:0] run_pri;
   logic [7:0]        run_slice;
   logic [7:0]        cfg_slice;
   logic [7:0]        cfg_age_limit;
   logic [3:0]        cfg_floor;

   function automatic bit ready_insert(logic [TASK_W-1:0] id, logic [TPRI_W-1:0] pri);
      int pos;
      if (ready_fill >= QUEUE_DEPTH) return 0;
      pos = ready_fill;
      for (int i = 0; i < ready_fill; i++) begin
         if (ready_pri[i] > pri) begin
            pos = i;
            break;
         end
      end
      for (int i = ready_fill; i > pos; i--) begin
         ready_task[i] = ready_task[i-1];
         ready_pri[i]  = ready_pri[i-1];
         ready_age[i]  = ready_age[i-1];
      end
      ready_task[pos] = id;
      ready_pri[pos]  = pri;
      ready_age[pos]  = '0;
      ready_fill++;
      return 1;
   endfunction

   function automatic void ready_remove(int pos);
      if (pos >= ready_fill) return;
      for (int i = pos; i + 1 < ready_fill; i++) begin
         ready_task[i] = ready_task[i+1];
         ready_pri[i]  = ready_pri[i+1];
         ready_age[i]  = ready_age[i+1];
      end
      ready_fill--;
   endfunction

   function automatic void sched_tick(logic still, output logic [STS_W-1:0] sts,
                                      output logic sw);
      logic              running;
      logic [TASK_W-1:0] nid;
      logic [TPRI_W-1:0] npri;
      sts = STS_DONE;
      sw  = 1'b0;
      // promoted entries only move forward, so the walk sees each once
      for (int i = 0; i < ready_fill; i++) begin
         if (ready_age[i] != AGE_MAX) ready_age[i]++;
         if (ready_age[i] >= cfg_age_limit && ready_pri[i] > cfg_floor) begin
            nid  = ready_task[i];
            npri = ready_pri[i] - 1'b1;
            ready_remove(i);
            void'(ready_insert(nid, npri));
         end
      end
      running = run_flag && still;
      if (running && run_slice != 0) run_slice--;
      if (running && run_slice != 0 && (ready_fill == 0 || run_pri <= ready_pri[0])) return;
      if (ready_fill == 0) begin
         if (running) begin
            run_slice = cfg_slice;
            return;
         end
         run_flag  = 1'b0;
         run_id    = '0;
         run_pri   = '0;
         run_slice = '0;
         sts = STS_IDLE;
         return;
      end
      nid  = ready_task[0];
      npri = ready_pri[0];
      ready_remove(0);
      if (running) void'(ready_insert(run_id, run_pri));
      run_id    = nid;
      run_pri   = npri;
      run_flag  = 1'b1;
      run_slice = cfg_slice;
      sw = 1'b1;
   endfunction

   function automatic sched_outcome_type sched_predict(logic [REQ_W-1:0] kind,
         logic [TASK_W-1:0] id, logic [TPRI_W-1:0] pri, logic still);
      sched_outcome_type o;
      o.status   = STS_DONE;
      o.switched = 1'b0;
      case (kind)
         REQ_READY: begin
            if (!ready_insert(id, pri)) o.status = STS_FULL;
         end
         REQ_WITHDRAW: begin
            o.status = STS_MISS;
            for (int i = 0; i < ready_fill; i++) begin
               if (ready_task[i] == id) begin
                  ready_remove(i);
                  o.status = STS_DONE;
                  break;
               end
            end
         end
         REQ_TICK: sched_tick(still, o.status, o.switched);
         default: ;
      endcase
      o.task_id    = run_flag ? run_id : '0;
      o.task_valid = run_flag;
      o.count      = 5'(ready_fill);
      return o;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: result %0d mismatch in %s: got %0d, want %0d",
               $realtime, results_seen, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      sched_outcome_type want;
      if (reset) begin
         sched_outcomes.delete();
         ready_fill    = 0;
         run_id        = '0;
         run_flag      = 1'b0;
         run_pri       = '0;
         run_slice     = '0;
         cfg_slice     = SLICE_RST;
         cfg_age_limit = AGE_LIMIT_RST;
         cfg_floor     = FLOOR_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLICE_LENGTH:   cfg_slice     = csr_wdata;
               CSR_AGE_LIMIT:      cfg_age_limit = csr_wdata;
               CSR_PRIORITY_FLOOR: cfg_floor     = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            sched_outcomes.push_back(sched_predict(req_type, req_task_id,
                                     req_task_priority, req_running_still_active));
         if (rsp_valid && !rsp_stall) begin
            if (sched_outcomes.size() == 0) begin
               $display("%0t: result with no request outstanding", $realtime);
               mismatches++;
            end else begin
               want = sched_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_switched !== want.switched)
                  report_mismatch("switched", rsp_switched, want.switched);
               if (rsp_active_task !== want.task_id)
                  report_mismatch("active_task", rsp_active_task, want.task_id);
               if (rsp_active_valid !== want.task_valid)
                  report_mismatch("active_valid", rsp_active_valid, want.task_valid);
               if (rsp_queued_count !== want.count)
                  report_mismatch("queued_count", rsp_queued_count, want.count);
               if (want.switched) switches_seen++;
               if (want.status == STS_IDLE) idles_seen++;
               if (want.status == STS_FULL) drops_seen++;
            end
            results_seen++;
         end
      end
      outstanding = sched_outcomes.size();
   end

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      results_seen  = 0;
      switches_seen = 0;
      idles_seen    = 0;
      drops_seen    = 0;
   end

endmodule

FILE: tb/sv/tb_priority_aging_scheduler_top.sv
// Testbench top for priority_aging_scheduler_top: clock, reset, request and
// register stimulus, result stall pattern and the verdict. Uses pas_checker
// for prediction and comparison; depends on pas_pkg.
module tb_priority_aging_scheduler_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pas_pkg::*;

   localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
   localparam int CYCLE_LIMIT = 600000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [REQ_W-1:0]     req_type = REQ_NOP;
   logic [TASK_W-1:0]    req_task_id = '0;
   logic [TPRI_W-1:0]    req_task_priority = '0;
   logic                 req_running_still_active = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STS_W-1:0]     rsp_status;
   logic                 rsp_switched;
   logic [TASK_W-1:0]    rsp_active_task;
   logic                 rsp_active_valid;
   logic [4:0]           rsp_queued_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SLICE_LENGTH;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int mismatches, outstanding, results_seen, switches_seen, idles_seen, drops_seen;
   int cycles = 0;
   int requests_sent = 0;
   bit steady = 0;        // no idling on either side while set
   bit hold_off = 0;      // asks the result side for one long stall
   int hold_left = 0;

   always #5 clock = ~clock;

   priority_aging_scheduler_top uut (.*);

   pas_checker checker_i (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // result side stall pattern, including the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_off) begin
         hold_off = 0;
         hold_left = 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 32);
      end
   end

   task automatic send_request(logic [REQ_W-1:0] kind, logic [TASK_W-1:0] id,
                               logic [TPRI_W-1:0] pri, logic still);
      if (!steady && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_type                 <= kind;
      req_task_id              <= id;
      req_task_priority        <= pri;
      req_running_still_active <= still;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic random_request();
      int pick;
      logic [REQ_W-1:0] kind;
      pick = $urandom_range(99);
      if (pick < 38)      kind = REQ_TICK;
      else if (pick < 72) kind = REQ_READY;
      else if (pick < 96) kind = REQ_WITHDRAW;
      else                kind = REQ_NOP;
      send_request(kind, 4'($urandom), 4'($urandom), ($urandom_range(99) < 80));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] slice, logic [7:0] age, logic [3:0] floor_pri);
      drain();
      repeat (40) @(posedge clock);
      write_register(CSR_SLICE_LENGTH, slice);
      write_register(CSR_AGE_LIMIT, age);
      write_register(CSR_PRIORITY_FLOOR, floor_pri);
   endtask

   initial begin
      logic [7:0] slices[6]  = '{8'd1, 8'd255, 8'd3, 8'd255, 8'd1, 8'd10};
      logic [7:0] ages[6]    = '{8'd1, 8'd255, 8'd2, 8'd1, 8'd255, 8'd8};
      logic [3:0] floors[6]  = '{4'd15, 4'd0, 4'd4, 4'd15, 4'd7, 4'd0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unused code, idle, dispatch, duplicate, withdraw hit and miss, full queue
      send_request(REQ_NOP, 4'd3, 4'd3, 1'b1);
      send_request(REQ_TICK, 4'd0, 4'd0, 1'b1);
      send_request(REQ_READY, 4'd0, 4'd15, 1'b0);
      send_request(REQ_READY, 4'd15, 4'd0, 1'b1);
      send_request(REQ_TICK, 4'd0, 4'd0, 1'b1);
      send_request(REQ_READY, 4'd15, 4'd0, 1'b0);
      send_request(REQ_WITHDRAW, 4'd15, 4'd0, 1'b0);
      send_request(REQ_WITHDRAW, 4'd9, 4'd15, 1'b1);
      for (int i = 0; i < 16; i++)
         send_request(REQ_READY, 4'(i), 4'($urandom), i[0]);
      send_request(REQ_TICK, 4'd15, 4'd15, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         configure(slices[ph], ages[ph], floors[ph]);
         if (ph == 1) steady = 1;
         if (ph == 2) begin
            hold_off = 1;
            repeat (40) random_request();
            drain();
         end
         for (int n = 0; n < 110; n++) begin
            // bursts of make-ready fill the queue now and then
            if (n % 50 == 49)
               repeat (18) send_request(REQ_READY, 4'($urandom), 4'($urandom), 1'b1);
            else
               random_request();
         end
         steady = 0;
      end

      drain();
      repeat (60) @(posedge clock);
      $display("Sent %0d requests over six register settings; %0d results checked",
               requests_sent, results_seen);
      $display("Dispatches %0d, idle ticks %0d, dropped inserts %0d",
               switches_seen, idles_seen, drops_seen);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
